/* rtl/core/usbcep_pkg.sv */
// ----------------------------------------------------------------------------
// usbcep_pkg
// Shared types and codes for the control endpoint handler: bus event codes,
// request codes, transfer phases, device states and endpoint buffer flags.
// ----------------------------------------------------------------------------
package usbcep_pkg;

  // bus event codes
  localparam logic [2:0] ACT_BUS_RESET = 3'd0;
  localparam logic [2:0] ACT_SETUP     = 3'd1;
  localparam logic [2:0] ACT_OUT_DONE  = 3'd2;
  localparam logic [2:0] ACT_IN_DONE   = 3'd3;
  localparam logic [2:0] ACT_STALL_CLR = 3'd4;

  // standard request codes
  localparam logic [7:0] REQ_SET_ADDRESS = 8'd5;
  localparam logic [7:0] REQ_GET_DESC    = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIG  = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIG  = 8'd9;

  // bmRequestType fields
  localparam logic [7:0] RTYPE_DIR_IN   = 8'h80;
  localparam logic [7:0] RTYPE_KIND_MSK = 8'h60;

  // descriptor kinds
  localparam logic [7:0] DESC_DEVICE = 8'd1;
  localparam logic [7:0] DESC_CONFIG = 8'd2;
  localparam logic [7:0] DESC_STRING = 8'd3;

  // reply sources
  localparam logic [2:0] SRC_DEVICE   = 3'd0;
  localparam logic [2:0] SRC_CONFIG   = 3'd1;
  localparam logic [2:0] SRC_STRING0  = 3'd2;
  localparam logic [2:0] SRC_STRING1  = 3'd3;
  localparam logic [2:0] SRC_STRING2  = 3'd4;
  localparam logic [2:0] SRC_STRING3  = 3'd5;
  localparam logic [2:0] SRC_CFG_BYTE = 3'd6;

  // control transfer phases
  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_TX   = 2'd1;
  localparam logic [1:0] PH_RX   = 2'd2;

  // device states
  localparam logic [2:0] DS_POWERED      = 3'd0;
  localparam logic [2:0] DS_DEFAULT      = 3'd1;
  localparam logic [2:0] DS_ADDR_PENDING = 3'd2;
  localparam logic [2:0] DS_ADDRESSED    = 3'd3;
  localparam logic [2:0] DS_CONFIGURED   = 3'd4;

  // configuration register file
  localparam int         CFG_REGS = 6;
  localparam logic [2:0] CFG_LAST = 3'd5;
  localparam logic [9:0] CFG_DEFAULT [CFG_REGS] =
    '{10'd18, 10'd9, 10'd4, 10'd0, 10'd0, 10'd0};

  // endpoint buffer flags
  typedef struct packed {
    logic in_armed;
    logic in_toggle;
    logic in_stall;
    logic out_armed;
    logic out_toggle;
    logic out_stall;
    logic out_data;
  } ep_flags_t;

  localparam ep_flags_t FLAGS_NONE  = '{default: 1'b0};
  localparam ep_flags_t FLAGS_SETUP = '{in_armed: 1'b0, in_toggle: 1'b0, in_stall: 1'b0,
                                        out_armed: 1'b1, out_toggle: 1'b0,
                                        out_stall: 1'b0, out_data: 1'b0};
  localparam ep_flags_t FLAGS_STALL = '{in_armed: 1'b1, in_toggle: 1'b0, in_stall: 1'b1,
                                        out_armed: 1'b1, out_toggle: 1'b0,
                                        out_stall: 1'b1, out_data: 1'b0};

  // one bus event
  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [7:0]  value_low;
    logic [7:0]  descriptor_kind;
    logic [15:0] requested_length;
  } event_t;

  // one result
  typedef struct packed {
    ep_flags_t   flags;
    logic [6:0]  in_count;
    logic [2:0]  in_source;
    logic [9:0]  in_offset;
    logic [6:0]  device_address;
    logic [2:0]  device_state;
  } result_t;

endpackage

/* rtl/core/usb_control_endpoint_handler.sv */
// ----------------------------------------------------------------------------
// usb_control_endpoint_handler
// Endpoint zero handler: steps the control transfer state on each bus event
// and reports both endpoint buffers, the address in force and device state.
// ----------------------------------------------------------------------------
// Pipeline: an event passes the event register, then the result register.
// Throughput: one event per cycle while the result side is not stalled;
//   the state update is one combinational pass.
// Reset: synchronous, active low; clears both channels, the endpoint state and
//   reloads the descriptor length registers with their defaults.
module usb_control_endpoint_handler #(
  parameter int PACKET_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  // event channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_request_type,
  input  logic [7:0]  in_request_code,
  input  logic [7:0]  in_value_low,
  input  logic [7:0]  in_descriptor_kind,
  input  logic [15:0] in_requested_length,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_in_armed,
  output logic        out_in_toggle,
  output logic        out_in_stall,
  output logic [6:0]  out_in_count,
  output logic [2:0]  out_in_source,
  output logic [9:0]  out_in_offset,
  output logic        out_out_armed,
  output logic        out_out_toggle,
  output logic        out_out_stall,
  output logic        out_out_to_data,
  output logic [6:0]  out_device_address,
  output logic [2:0]  out_device_state
);

  localparam logic [15:0] PktBytes = 16'(PACKET_BYTES);

  // largest chunk of the remaining reply that fits one packet
  function automatic logic [15:0] pkt_take(input logic [15:0] left);
    return (left < PktBytes) ? left : PktBytes;
  endfunction

  // pipeline handshake
  logic                 evt_vld_r;
  usbcep_pkg::event_t   evt_r;
  logic                 res_vld_r;
  usbcep_pkg::result_t  res_r;
  usbcep_pkg::result_t  res_nxt;
  logic                 advance;
  logic                 load_evt;

  assign advance  = evt_vld_r && (!res_vld_r || !out_stall);
  assign in_stall = evt_vld_r && !advance;
  assign load_evt = in_valid && !in_stall;

  // descriptor length registers
  logic [9:0] cfg_len_r [usbcep_pkg::CFG_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < usbcep_pkg::CFG_REGS; i++) begin
        cfg_len_r[i] <= usbcep_pkg::CFG_DEFAULT[i];
      end
    end else if (cfg_we && cfg_index <= usbcep_pkg::CFG_LAST) begin
      cfg_len_r[cfg_index] <= cfg_data;
    end
  end

  // event register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evt_vld_r <= 1'b0;
    end else if (load_evt) begin
      evt_vld_r <= 1'b1;
    end else if (advance) begin
      evt_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_evt) begin
      evt_r <= '{action: in_action, request_type: in_request_type,
                 request_code: in_request_code, value_low: in_value_low,
                 descriptor_kind: in_descriptor_kind,
                 requested_length: in_requested_length};
    end
  end

  // endpoint state
  logic [1:0]             phase_r, phase_nxt;
  logic [15:0]            bytes_left_r, bytes_left_nxt;
  logic [2:0]             reply_src_r, reply_src_nxt;
  logic [9:0]             reply_off_r, reply_off_nxt;
  logic [2:0]             bus_state_r, bus_state_nxt;
  logic [6:0]             pend_addr_r, pend_addr_nxt;
  logic [6:0]             cur_addr_r, cur_addr_nxt;
  usbcep_pkg::ep_flags_t  flags_r, flags_nxt;
  logic [6:0]             last_cnt_r, last_cnt_nxt;

  // next state for the event in the event register
  always_comb begin
    logic        req_stall;
    logic [15:0] len_v;
    logic [15:0] take_v;
    logic [2:0]  src_v;
    logic [9:0]  desc_len;

    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    reply_src_nxt  = reply_src_r;
    reply_off_nxt  = reply_off_r;
    bus_state_nxt  = bus_state_r;
    pend_addr_nxt  = pend_addr_r;
    cur_addr_nxt   = cur_addr_r;
    flags_nxt      = flags_r;
    last_cnt_nxt   = last_cnt_r;
    req_stall      = 1'b0;
    len_v          = 16'd0;
    take_v         = 16'd0;
    src_v          = reply_src_r;
    desc_len       = 10'd0;

    if (evt_r.action == usbcep_pkg::ACT_BUS_RESET) begin
      cur_addr_nxt  = 7'd0;
      phase_nxt     = usbcep_pkg::PH_WAIT;
      flags_nxt     = usbcep_pkg::FLAGS_SETUP;
      bus_state_nxt = usbcep_pkg::DS_DEFAULT;
    end else if (bus_state_r != usbcep_pkg::DS_POWERED) begin
      unique case (evt_r.action)
        usbcep_pkg::ACT_SETUP: begin
          // request decode
          if ((evt_r.request_type & usbcep_pkg::RTYPE_KIND_MSK) != 8'd0) begin
            req_stall = 1'b1;
          end else begin
            unique case (evt_r.request_code)
              usbcep_pkg::REQ_SET_ADDRESS: begin
                pend_addr_nxt = evt_r.value_low[6:0];
                bus_state_nxt = usbcep_pkg::DS_ADDR_PENDING;
              end
              usbcep_pkg::REQ_GET_DESC: begin
                priority if (evt_r.descriptor_kind == usbcep_pkg::DESC_DEVICE) begin
                  src_v = usbcep_pkg::SRC_DEVICE;
                end else if (evt_r.descriptor_kind == usbcep_pkg::DESC_CONFIG) begin
                  src_v = usbcep_pkg::SRC_CONFIG;
                end else if (evt_r.descriptor_kind == usbcep_pkg::DESC_STRING) begin
                  if (evt_r.value_low >= 8'd1 && evt_r.value_low <= 8'd3) begin
                    src_v = usbcep_pkg::SRC_STRING0 + {1'b0, evt_r.value_low[1:0]};
                  end else begin
                    src_v = usbcep_pkg::SRC_STRING0;
                  end
                end else begin
                  req_stall = 1'b1;
                end
                unique case (src_v)
                  usbcep_pkg::SRC_DEVICE:  desc_len = cfg_len_r[0];
                  usbcep_pkg::SRC_CONFIG:  desc_len = cfg_len_r[1];
                  usbcep_pkg::SRC_STRING0: desc_len = cfg_len_r[2];
                  usbcep_pkg::SRC_STRING1: desc_len = cfg_len_r[3];
                  usbcep_pkg::SRC_STRING2: desc_len = cfg_len_r[4];
                  usbcep_pkg::SRC_STRING3: desc_len = cfg_len_r[5];
                  default:                 desc_len = 10'd0;
                endcase
                if (!req_stall) begin
                  reply_src_nxt = src_v;
                  reply_off_nxt = 10'd0;
                  len_v         = {6'd0, desc_len};
                end
              end
              usbcep_pkg::REQ_SET_CONFIG: begin
                bus_state_nxt = (evt_r.value_low == 8'd0) ? usbcep_pkg::DS_ADDRESSED
                                                          : usbcep_pkg::DS_CONFIGURED;
              end
              usbcep_pkg::REQ_GET_CONFIG: begin
                reply_src_nxt = usbcep_pkg::SRC_CFG_BYTE;
                reply_off_nxt = 10'd0;
                len_v         = 16'd1;
              end
              default: req_stall = 1'b1;
            endcase
          end

          // data stage setup
          if (req_stall) begin
            bytes_left_nxt = 16'd0;
            phase_nxt      = usbcep_pkg::PH_WAIT;
            flags_nxt      = usbcep_pkg::FLAGS_STALL;
          end else if ((evt_r.request_type & usbcep_pkg::RTYPE_DIR_IN) != 8'd0) begin
            if (evt_r.requested_length < len_v) begin
              len_v = evt_r.requested_length;
            end
            take_v               = pkt_take(len_v);
            last_cnt_nxt         = take_v[6:0];
            bytes_left_nxt       = len_v - take_v;
            phase_nxt            = usbcep_pkg::PH_TX;
            flags_nxt            = usbcep_pkg::FLAGS_SETUP;
            flags_nxt.in_armed   = 1'b1;
            flags_nxt.in_toggle  = 1'b1;
          end else begin
            bytes_left_nxt       = len_v;
            last_cnt_nxt         = 7'd0;
            phase_nxt            = usbcep_pkg::PH_RX;
            flags_nxt            = usbcep_pkg::FLAGS_SETUP;
            flags_nxt.out_toggle = 1'b1;
            flags_nxt.out_data   = 1'b1;
            flags_nxt.in_armed   = 1'b1;
            flags_nxt.in_toggle  = 1'b1;
          end
        end
        usbcep_pkg::ACT_OUT_DONE: begin
          if (phase_r == usbcep_pkg::PH_RX) begin
            flags_nxt.out_toggle = !flags_r.out_toggle;
          end else begin
            phase_nxt = usbcep_pkg::PH_WAIT;
            flags_nxt = usbcep_pkg::FLAGS_SETUP;
          end
        end
        usbcep_pkg::ACT_IN_DONE: begin
          // pending address takes effect after the status stage
          if (bus_state_r == usbcep_pkg::DS_ADDR_PENDING) begin
            cur_addr_nxt  = pend_addr_r;
            bus_state_nxt = (pend_addr_r != 7'd0) ? usbcep_pkg::DS_ADDRESSED
                                                  : usbcep_pkg::DS_DEFAULT;
          end
          if (phase_r == usbcep_pkg::PH_TX) begin
            reply_off_nxt       = reply_off_r + {3'd0, last_cnt_r};
            take_v              = pkt_take(bytes_left_r);
            last_cnt_nxt        = take_v[6:0];
            bytes_left_nxt      = bytes_left_r - take_v;
            flags_nxt.in_toggle = !flags_r.in_toggle;
            flags_nxt.in_armed  = 1'b1;
            flags_nxt.in_stall  = 1'b0;
          end else begin
            phase_nxt = usbcep_pkg::PH_WAIT;
            flags_nxt = usbcep_pkg::FLAGS_SETUP;
          end
        end
        usbcep_pkg::ACT_STALL_CLR: begin
          phase_nxt = usbcep_pkg::PH_WAIT;
          flags_nxt = usbcep_pkg::FLAGS_SETUP;
        end
        default: ;
      endcase
    end
  end

  // result assembly from the updated state
  always_comb begin
    res_nxt.flags          = flags_nxt;
    res_nxt.in_count       = last_cnt_nxt;
    res_nxt.in_source      = (phase_nxt == usbcep_pkg::PH_TX) ? reply_src_nxt : 3'd0;
    res_nxt.in_offset      = (phase_nxt == usbcep_pkg::PH_TX) ? reply_off_nxt : 10'd0;
    res_nxt.device_address = cur_addr_nxt;
    res_nxt.device_state   = bus_state_nxt;
  end

  // state registers, updated as the event moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= usbcep_pkg::PH_WAIT;
      bytes_left_r <= 16'd0;
      reply_src_r  <= 3'd0;
      reply_off_r  <= 10'd0;
      bus_state_r  <= usbcep_pkg::DS_POWERED;
      pend_addr_r  <= 7'd0;
      cur_addr_r   <= 7'd0;
      flags_r      <= usbcep_pkg::FLAGS_NONE;
      last_cnt_r   <= 7'd0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      reply_src_r  <= reply_src_nxt;
      reply_off_r  <= reply_off_nxt;
      bus_state_r  <= bus_state_nxt;
      pend_addr_r  <= pend_addr_nxt;
      cur_addr_r   <= cur_addr_nxt;
      flags_r      <= flags_nxt;
      last_cnt_r   <= last_cnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (advance) begin
      res_vld_r <= 1'b1;
    end else if (!out_stall) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  // result ports
  assign out_valid          = res_vld_r;
  assign out_in_armed       = res_r.flags.in_armed;
  assign out_in_toggle      = res_r.flags.in_toggle;
  assign out_in_stall       = res_r.flags.in_stall;
  assign out_in_count       = res_r.in_count;
  assign out_in_source      = res_r.in_source;
  assign out_in_offset      = res_r.in_offset;
  assign out_out_armed      = res_r.flags.out_armed;
  assign out_out_toggle     = res_r.flags.out_toggle;
  assign out_out_stall      = res_r.flags.out_stall;
  assign out_out_to_data    = res_r.flags.out_data;
  assign out_device_address = res_r.device_address;
  assign out_device_state   = res_r.device_state;

endmodule

/* rtl/core/usbcep_checker.sv */
// ----------------------------------------------------------------------------
// usbcep_checker
// Port-level checks for the control endpoint handler, bound to the top level.
// ----------------------------------------------------------------------------
module usbcep_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_in_armed,
  input logic        out_in_stall,
  input logic [6:0]  out_in_count,
  input logic [2:0]  out_in_source,
  input logic [9:0]  out_in_offset,
  input logic        out_out_stall,
  input logic        out_out_to_data,
  input logic [2:0]  out_device_state
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_in_count)
      && $stable(out_in_source) && $stable(out_in_offset)
      && $stable(out_device_state))
    else $error("stalled result changed");

  // the event side only backs up when the result side is stalled
  a_in_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled with free result side");

  // a stalled IN endpoint always comes with a stalled OUT endpoint
  a_stall_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_stall |-> out_out_stall)
    else $error("IN stall without OUT stall");

  // reply fields only show during a data-in stage, where IN is armed
  a_reply_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_in_source != 3'd0 || out_in_offset != 10'd0)
      |-> out_in_armed && !out_out_to_data && !out_out_stall)
    else $error("reply fields outside data-in stage");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind usb_control_endpoint_handler usbcep_checker u_usbcep_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_in_armed     (out_in_armed),
  .out_in_stall     (out_in_stall),
  .out_in_count     (out_in_count),
  .out_in_source    (out_in_source),
  .out_in_offset    (out_in_offset),
  .out_out_stall    (out_out_stall),
  .out_out_to_data  (out_out_to_data),
  .out_device_state (out_device_state)
);
